// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle check.
`define PLUM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("plum check failed");
// Check in the cycle after a condition.
`define PLUM_ASSERT_NEXT(lbl, clk, rstn, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) cond |=> prop) \
    else $error("plum check failed");
`endif

// ===== rtl/core/plum_pkg.sv =====
package plum_pkg;
  localparam int unsigned MaxPrefixes = 4;
  localparam int unsigned CfgIdxW     = 4;
  localparam int unsigned CfgRegs     = 8;
  localparam int unsigned CntOutW     = 9;
  localparam logic        SelLen      = 1'b1;
  localparam logic        ModeRelease = 1'b1;
  localparam logic [31:0] AllOnes     = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        mode;
    logic [31:0] addr;
    logic [3:0]  elig;
  } job_t;

  typedef struct packed {
    logic [3:0][31:0] addr;
    logic [3:0][4:0]  len;
  } cfg_t;
endpackage

// ===== rtl/core/plum_if.sv =====
interface plum_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] client_addr;
  modport source (output valid, mode, client_addr, input ready);
  modport sink (input valid, mode, client_addr, output ready);
endinterface

interface plum_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] changed_mask;
  logic [3:0] alert_mask;
  logic [3:0] half_mask;
  logic [3:0] drop_mask;
  logic [8:0] count_0;
  logic [8:0] count_1;
  logic [8:0] count_2;
  logic [8:0] count_3;
  modport source (output valid, changed_mask, alert_mask, half_mask, drop_mask,
                  count_0, count_1, count_2, count_3, input ready);
  modport sink (input valid, changed_mask, alert_mask, half_mask, drop_mask,
                count_0, count_1, count_2, count_3, output ready);
endinterface

interface plum_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/prefix_lease_utilization_monitor.sv =====
// Lease utilization monitor for up to four IPv4 prefixes.
// Channels: req_i takes one lease request (mode 0 assign, 1 release, plus the
// client address); rsp_o returns one result per request with per-prefix
// changed/alert/half/drop masks and the counts after the request; cfg_i
// writes prefix address and length registers (index 2k address, 2k+1 length).
// A request is classified against the prefixes on acceptance and queued
// (two entries). The back end then scans every prefix store in parallel, one
// slot per cycle through the registered RAM read port, and then applies the
// update for all prefixes together. It takes a new request from the queue
// only while idle, so requests are handled one at a time.
// After reset the stores are cleared by a pass over every slot; req_i is
// held not ready meanwhile, configuration writes are taken throughout.
// A stalled rsp_o holds its result; the back end waits with the next update
// while up to two more requests are still accepted into the queue.
module prefix_lease_utilization_monitor #(
  parameter int unsigned NUM_PREFIXES = 4,
  parameter int unsigned STORE_DEPTH  = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  plum_in_if.sink    req_i,
  plum_out_if.source rsp_o,
  plum_cfg_if.sink   cfg_i
);
  import plum_pkg::*;

  cfg_t cfg;
  job_t push_job, pop_job;
  logic push_valid, push_ready, pop_valid, pop_ready, clearing;

  plum_front #(.NUM_PREFIXES(NUM_PREFIXES)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_i       (cfg_i),
    .clearing_i  (clearing),
    .cfg_o       (cfg),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .job_o       (push_job)
  );

  plum_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_job_i  (push_job),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_job_o   (pop_job)
  );

  plum_back #(.NUM_PREFIXES(NUM_PREFIXES), .STORE_DEPTH(STORE_DEPTH)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .job_i      (pop_job),
    .cfg_i      (cfg),
    .clearing_o (clearing),
    .rsp_o      (rsp_o)
  );
endmodule

// ===== rtl/core/plum_ram.sv =====
module plum_ram #(
  parameter int unsigned Width = 33,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/core/plum_front.sv =====
module plum_front #(
  parameter int unsigned NUM_PREFIXES = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  plum_in_if.sink        req_i,
  plum_cfg_if.sink       cfg_i,
  input  logic           clearing_i,
  output plum_pkg::cfg_t cfg_o,
  output logic           push_valid_o,
  input  logic           push_ready_i,
  output plum_pkg::job_t job_o
);
  import plum_pkg::*;

  cfg_t cfg_q;
  logic [3:0] elig;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid && cfg_i.index < CfgIdxW'(CfgRegs)) begin
      if (cfg_i.index[0] == SelLen) begin
        cfg_q.len[cfg_i.index[2:1]] <= cfg_i.data[4:0];
      end else begin
        cfg_q.addr[cfg_i.index[2:1]] <= cfg_i.data;
      end
    end
  end

  // host part masked off by the prefix length; network and broadcast excluded; only lengths 1 to 30 match
  always_comb begin
    logic [5:0]  sh;
    logic [31:0] mask;
    logic [31:0] bcast;
    elig = '0;
    for (int p = 0; p < MaxPrefixes; p++) begin
      sh    = 6'd32 - {1'b0, cfg_q.len[p]};
      mask  = AllOnes << sh;
      bcast = cfg_q.addr[p] | ~mask;
      if (p < NUM_PREFIXES && cfg_q.len[p] >= 5'd1 && cfg_q.len[p] <= 5'd30 &&
          req_i.client_addr != cfg_q.addr[p] && req_i.client_addr != bcast &&
          (req_i.client_addr & mask) == (cfg_q.addr[p] & mask)) begin
        elig[p] = 1'b1;
      end
    end
  end

  assign req_i.ready  = push_ready_i && !clearing_i;
  assign push_valid_o = req_i.valid && !clearing_i;
  assign job_o        = '{mode: req_i.mode, addr: req_i.client_addr, elig: elig};
  assign cfg_o        = cfg_q;
endmodule

// ===== rtl/core/plum_queue.sv =====
module plum_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  plum_pkg::job_t push_job_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output plum_pkg::job_t pop_job_o
);
  import plum_pkg::*;

  job_t       ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = cnt_q != 2'd2;
  assign pop_valid_o  = cnt_q != 2'd0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_job_o    = ent_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wp_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== rtl/core/plum_back.sv =====
`include "assert_macros.svh"
module plum_back #(
  parameter int unsigned NUM_PREFIXES = 4,
  parameter int unsigned STORE_DEPTH  = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  output logic           pop_ready_o,
  input  plum_pkg::job_t job_i,
  input  plum_pkg::cfg_t cfg_i,
  output logic           clearing_o,
  plum_out_if.source     rsp_o
);
  import plum_pkg::*;

  localparam int unsigned IW = $clog2(STORE_DEPTH);
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);

  localparam logic [2:0] SClear = 3'd0;
  localparam logic [2:0] SIdle  = 3'd1;
  localparam logic [2:0] SScan  = 3'd2;
  localparam logic [2:0] SWrite = 3'd3;

  function automatic logic half_f(input logic [4:0] len, input logic [15:0] cnt);
    logic [5:0]  sh;
    logic [17:0] hosts;
    logic [17:0] dbl;
    logic        r;
    sh    = 6'd32 - {1'b0, len};
    hosts = (18'd1 << sh) - 18'd2;
    dbl   = {1'b0, cnt, 1'b0};
    if (len == 5'd0 || len > 5'd30 || sh > 6'd16) r = 1'b0;
    else r = dbl >= hosts;
    return r;
  endfunction

  logic [2:0]    state_q, state_d;
  logic [IW:0]   k_q;
  job_t          job_q;
  logic          rdv_q;
  logic [IW-1:0] rdidx_q;
  logic [IW-1:0] raddr;

  logic [3:0]          found_q, free_q;
  logic [3:0][IW-1:0]  fidx_q, freeidx_q;
  logic [3:0][CW-1:0]  cnt_q, cnt_nxt;
  logic [3:0]          latch_q, latch_nxt;
  logic [3:0][32:0]    rdata;
  logic [3:0]          we;
  logic [3:0][IW-1:0]  waddr;
  logic [3:0][32:0]    wdata;
  logic [3:0]          ins, rel, drp, chg, alr;
  logic                fire, taken;

  logic                   rsp_valid_q;
  logic [3:0]             rsp_chg_q, rsp_alert_q, rsp_half_q, rsp_drop_q;
  logic [3:0][CntOutW-1:0] rsp_cnt_q;

  assign raddr       = k_q[IW-1:0];
  assign fire        = state_q == SWrite && (!rsp_valid_q || rsp_o.ready);
  assign pop_ready_o = state_q == SIdle;
  assign clearing_o  = state_q == SClear;

  for (genvar p = 0; p < MaxPrefixes; p++) begin : g_store
    if (p < NUM_PREFIXES) begin : g_on
      plum_ram #(.Width(33), .Depth(STORE_DEPTH)) u_ram (
        .clk_i  (clk_i),
        .we_i   (we[p]),
        .waddr_i(waddr[p]),
        .wdata_i(wdata[p]),
        .raddr_i(raddr),
        .rdata_o(rdata[p])
      );
    end else begin : g_off
      assign rdata[p] = '0;
    end
  end

  // per-prefix decisions once the scan has finished, and the clearing writes after reset
  always_comb begin
    logic done;
    done = 1'b0;
    for (int p = 0; p < MaxPrefixes; p++) begin
      ins[p] = job_q.mode != ModeRelease && job_q.elig[p] && !found_q[p] && free_q[p];
      drp[p] = job_q.mode != ModeRelease && job_q.elig[p] && !found_q[p] && !free_q[p];
      rel[p] = 1'b0;
      if (job_q.mode == ModeRelease && found_q[p] && !done) begin
        rel[p] = 1'b1;
        done   = 1'b1;
      end
      chg[p] = ins[p] | rel[p];
      if (ins[p]) cnt_nxt[p] = cnt_q[p] + CW'(1);
      else if (rel[p] && cnt_q[p] != '0) cnt_nxt[p] = cnt_q[p] - CW'(1);
      else cnt_nxt[p] = cnt_q[p];
      latch_nxt[p] = chg[p] ? half_f(cfg_i.len[p], 16'(cnt_nxt[p])) : latch_q[p];
      alr[p]       = chg[p] && latch_nxt[p] && !latch_q[p];
      if (state_q == SClear) begin
        we[p]    = 1'b1;
        waddr[p] = k_q[IW-1:0];
        wdata[p] = '0;
      end else begin
        we[p]    = fire && chg[p];
        waddr[p] = ins[p] ? freeidx_q[p] : fidx_q[p];
        wdata[p] = ins[p] ? {1'b1, job_q.addr} : 33'd0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    taken   = 1'b0;
    case (state_q)
      SClear: if (k_q == (IW+1)'(STORE_DEPTH - 1)) state_d = SIdle;
      SIdle: begin
        if (pop_valid_i) begin
          taken   = 1'b1;
          state_d = SScan;
        end
      end
      SScan:  if (k_q == (IW+1)'(STORE_DEPTH)) state_d = SWrite;
      SWrite: if (fire) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (taken) job_q <= job_i;
    rdidx_q <= raddr;
    if (taken) begin
      found_q <= '0;
      free_q  <= '0;
    end else if (rdv_q) begin
      for (int p = 0; p < MaxPrefixes; p++) begin
        if (rdata[p][32] && rdata[p][31:0] == job_q.addr && !found_q[p]) begin
          found_q[p] <= 1'b1;
          fidx_q[p]  <= rdidx_q;
        end
        if (!rdata[p][32] && !free_q[p]) begin
          free_q[p]    <= 1'b1;
          freeidx_q[p] <= rdidx_q;
        end
      end
    end
    if (fire) begin
      rsp_chg_q   <= chg;
      rsp_alert_q <= alr;
      rsp_half_q  <= latch_nxt;
      rsp_drop_q  <= drp;
      for (int p = 0; p < MaxPrefixes; p++) begin
        rsp_cnt_q[p] <= CntOutW'(32'(cnt_nxt[p]));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      k_q         <= '0;
      rdv_q       <= 1'b0;
      cnt_q       <= '0;
      latch_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rdv_q   <= state_q == SScan && k_q < (IW+1)'(STORE_DEPTH);
      if (state_q == SClear || state_q == SScan) k_q <= k_q + (IW+1)'(1);
      else k_q <= '0;
      if (fire) begin
        cnt_q   <= cnt_nxt;
        latch_q <= latch_nxt;
      end
      if (fire) rsp_valid_q <= 1'b1;
      else if (rsp_o.ready) rsp_valid_q <= 1'b0;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.changed_mask = rsp_chg_q;
  assign rsp_o.alert_mask   = rsp_alert_q;
  assign rsp_o.half_mask    = rsp_half_q;
  assign rsp_o.drop_mask    = rsp_drop_q;
  assign rsp_o.count_0      = rsp_cnt_q[0];
  assign rsp_o.count_1      = rsp_cnt_q[1];
  assign rsp_o.count_2      = rsp_cnt_q[2];
  assign rsp_o.count_3      = rsp_cnt_q[3];

  `PLUM_ASSERT(a_rel_single, clk_i, rst_ni, ((fire && job_q.mode == ModeRelease) |-> $onehot0(chg)))
  `PLUM_ASSERT(a_drop_nochg, clk_i, rst_ni, (rsp_valid_q |-> ((rsp_chg_q & rsp_drop_q) == 4'd0)))
  `PLUM_ASSERT(a_alert_half, clk_i, rst_ni, (rsp_valid_q |-> ((rsp_alert_q & ~rsp_half_q) == 4'd0)))
  `PLUM_ASSERT_NEXT(a_fire_rsp, clk_i, rst_ni, fire, (rsp_valid_q && state_q == SIdle))
endmodule

// ===== bench/plum_checker.sv =====
`timescale 1ns / 1ps

module plum_checker (
  input  logic clk_i,
  input  logic rst_ni,
  plum_in_if   req,
  plum_out_if  rsp,
  plum_cfg_if  cfg,
  output int   errors_o,
  output int   pending_o
);
  import plum_pkg::*;

  localparam int unsigned Depth = 256;

  typedef struct packed {
    logic [3:0]       changed;
    logic [3:0]       alert;
    logic [3:0]       half;
    logic [3:0]       drop;
    logic [3:0][8:0]  count;
  } lease_result_t;

  logic [31:0] pfx_addr [MaxPrefixes];
  logic [4:0]  pfx_len  [MaxPrefixes];
  logic [31:0] lease_addr [MaxPrefixes][Depth];
  bit          lease_used [MaxPrefixes][Depth];
  int unsigned lease_cnt  [MaxPrefixes];
  bit          half_latch [MaxPrefixes];

  lease_result_t expected_results[$];
  int mismatches;

  assign errors_o  = mismatches;
  assign pending_o = expected_results.size();

  function automatic bit len_on(logic [4:0] len);
    return len >= 1 && len <= 30;
  endfunction

  function automatic bit in_prefix(int p, logic [31:0] a);
    logic [31:0] host_bits;
    host_bits = ~(AllOnes << (32 - pfx_len[p]));
    if (a == pfx_addr[p] || a == (pfx_addr[p] | host_bits)) return 0;
    return (a & ~host_bits) == (pfx_addr[p] & ~host_bits);
  endfunction

  function automatic int slot_of(int p, logic [31:0] a);
    for (int i = 0; i < Depth; i++)
      if (lease_used[p][i] && lease_addr[p][i] == a) return i;
    return -1;
  endfunction

  // returns 1 when the latch rises
  function automatic bit relatch(int p);
    bit old;
    bit now;
    longint unsigned hosts;
    old = half_latch[p];
    now = 0;
    if (len_on(pfx_len[p])) begin
      hosts = (64'd1 << (32 - pfx_len[p])) - 2;
      now = 2 * longint'(lease_cnt[p]) >= hosts;
    end
    half_latch[p] = now;
    return now && !old;
  endfunction

  function automatic lease_result_t apply_lease(logic mode, logic [31:0] a);
    lease_result_t r;
    int s;
    r = '0;
    if (mode == ModeRelease) begin
      for (int p = 0; p < MaxPrefixes; p++) begin
        s = slot_of(p, a);
        if (s >= 0) begin
          lease_used[p][s] = 0;
          if (lease_cnt[p] > 0) lease_cnt[p]--;
          r.changed[p] = 1;
          r.alert[p] = relatch(p);
          break;
        end
      end
    end else begin
      for (int p = 0; p < MaxPrefixes; p++) begin
        if (!len_on(pfx_len[p]) || !in_prefix(p, a) || slot_of(p, a) >= 0) continue;
        s = -1;
        for (int i = 0; i < Depth; i++)
          if (!lease_used[p][i]) begin
            s = i;
            break;
          end
        if (s < 0) begin
          r.drop[p] = 1;
          continue;
        end
        lease_addr[p][s] = a;
        lease_used[p][s] = 1;
        lease_cnt[p]++;
        r.changed[p] = 1;
        r.alert[p] = relatch(p);
      end
    end
    for (int p = 0; p < MaxPrefixes; p++) begin
      r.half[p] = half_latch[p];
      r.count[p] = lease_cnt[p][8:0];
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    lease_result_t exp_r;
    lease_result_t got;
    if (!rst_ni) begin
      mismatches = 0;
      expected_results.delete();
      for (int p = 0; p < MaxPrefixes; p++) begin
        pfx_addr[p] = '0;
        pfx_len[p] = '0;
        lease_cnt[p] = 0;
        half_latch[p] = 0;
        for (int i = 0; i < Depth; i++) lease_used[p][i] = 0;
      end
    end else begin
      if (cfg.valid && cfg.ready && cfg.index < CfgIdxW'(CfgRegs)) begin
        if (cfg.index[0] == SelLen) pfx_len[cfg.index[2:1]] = cfg.data[4:0];
        else pfx_addr[cfg.index[2:1]] = cfg.data;
      end
      if (req.valid && req.ready)
        expected_results = {expected_results, apply_lease(req.mode, req.client_addr)};
      if (rsp.valid && rsp.ready) begin
        got.changed = rsp.changed_mask;
        got.alert = rsp.alert_mask;
        got.half = rsp.half_mask;
        got.drop = rsp.drop_mask;
        got.count = {rsp.count_3, rsp.count_2, rsp.count_1, rsp.count_0};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response %h", got);
        end else begin
          exp_r = expected_results.pop_front();
          if (got.changed !== exp_r.changed || got.alert !== exp_r.alert ||
              got.half !== exp_r.half || got.drop !== exp_r.drop ||
              got.count !== exp_r.count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: chg %h/%h alert %h/%h half %h/%h drop %h/%h cnt %h/%h",
                       exp_r.changed, got.changed, exp_r.alert, got.alert,
                       exp_r.half, got.half, exp_r.drop, got.drop,
                       exp_r.count, got.count);
          end
        end
      end
    end
  end
endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import plum_pkg::*;

  localparam logic ModeAssign = ~ModeRelease;

  logic clk_i;
  logic rst_ni;
  int   errors;
  int   pending;
  bit   quiet;
  bit   stall_req;
  logic [31:0] cur_addr [MaxPrefixes];
  logic [4:0]  cur_len  [MaxPrefixes];
  logic [31:0] leased[$];

  plum_in_if  req_if ();
  plum_out_if rsp_if ();
  plum_cfg_if cfg_if ();

  prefix_lease_utilization_monitor i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  plum_checker i_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg       (cfg_if),
    .errors_o  (errors),
    .pending_o (pending)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  initial begin
    #(8 * 3_000_000);
    $display("testbench failed");
    $finish;
  end

  // response side: random back-pressure bursts, plus one long hold-off
  initial begin
    int n;
    bit stalled;
    stalled = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_req && !stalled) begin
        stalled = 1'b1;
        rsp_if.ready = 1'b0;
        repeat (800) @(negedge clk_i);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        rsp_if.ready = 1'b0;
        n = $urandom_range(1, 6);
        repeat (n - 1) @(negedge clk_i);
      end else begin
        rsp_if.ready = 1'b1;
      end
    end
  end

  task automatic write_reg(logic [3:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = val;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic set_prefix(int k, logic [31:0] a, logic [4:0] len);
    logic [2:0] k3;
    k3 = k[2:0];
    write_reg({k3, ~SelLen}, a);
    write_reg({k3, SelLen}, {27'd0, len});
    cur_addr[k] = a;
    cur_len[k] = len;
  endtask

  task automatic send_lease(logic mode, logic [31:0] a);
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 6);
      @(negedge clk_i);
      req_if.valid = 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_if.valid       = 1'b1;
    req_if.mode        = mode;
    req_if.client_addr = a;
    do @(posedge clk_i); while (!req_if.ready);
    if (mode == ModeAssign) begin
      leased = {leased, a};
      if (leased.size() > 600) void'(leased.pop_front());
    end
  endtask

  task automatic drain_and_settle();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic random_leases(int count);
    int k;
    int kind;
    logic [31:0] base;
    logic [31:0] span;
    logic [31:0] a;
    logic mode;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        a = $urandom();
        mode = 1'($urandom_range(0, 1));
      end else if (kind >= 7 && leased.size() > 0) begin
        a = leased[$urandom_range(0, leased.size() - 1)];
        mode = ModeRelease;
      end else begin
        k = $urandom_range(0, MaxPrefixes - 1);
        span = (cur_len[k] >= 1 && cur_len[k] <= 23) ? 32'd511 :
               (cur_len[k] >= 24 && cur_len[k] <= 31) ? ((32'd1 << (32 - cur_len[k])) - 1) :
               32'd511;
        base = (cur_len[k] >= 1) ? (cur_addr[k] & (AllOnes << (32 - cur_len[k]))) : cur_addr[k];
        a = base | $urandom_range(0, span);
        mode = ($urandom_range(0, 99) < 65) ? ModeAssign : ModeRelease;
      end
      send_lease(mode, a);
    end
  endtask

  initial begin
    quiet = 0;
    stall_req = 0;
    req_if.valid = 1'b0;
    req_if.mode = ModeAssign;
    req_if.client_addr = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // overlapping prefixes: wide one that can fill its store, small ones for alerts
    set_prefix(0, 32'h0A00_0000, 5'd23);
    set_prefix(1, 32'h0A00_0000, 5'd28);
    set_prefix(2, 32'h0A00_0104, 5'd30);
    set_prefix(3, 32'hC0A8_0000, 5'd0);

    send_lease(ModeAssign, 32'h0A00_0000);   // network address
    send_lease(ModeAssign, 32'h0A00_01FF);   // broadcast of the wide prefix
    send_lease(ModeAssign, 32'h0A00_0001);
    send_lease(ModeAssign, 32'h0A00_0001);   // already held
    send_lease(ModeAssign, 32'h0A00_0105);
    send_lease(ModeAssign, 32'h0A00_0106);
    send_lease(ModeRelease, 32'h0A00_0105);
    send_lease(ModeRelease, 32'h0102_0304);  // never leased
    send_lease(ModeAssign, 32'h0000_0000);
    send_lease(ModeAssign, AllOnes);
    send_lease(ModeRelease, AllOnes);
    send_lease(ModeAssign, 32'h0A00_000F);
    send_lease(ModeRelease, 32'h0A00_0001);
    send_lease(ModeAssign, 32'hC0A8_0001);   // disabled prefix

    // fill the wide prefix past its store; the response side holds off once at the start
    stall_req = 1;
    for (int i = 1; i <= 300; i++) send_lease(ModeAssign, 32'h0A00_0000 + i);
    drain_and_settle();

    random_leases(420);
    drain_and_settle();

    set_prefix(0, 32'hFFFF_FFFC, 5'd30);
    set_prefix(1, 32'h8000_0000, 5'd1);
    set_prefix(2, 32'h0A00_0000, 5'd24);
    set_prefix(3, 32'h0A00_0010, 5'd29);
    random_leases(400);
    drain_and_settle();

    // disabled lengths; releases still reach addresses held before
    set_prefix(0, 32'h0A00_0000, 5'd31);
    set_prefix(1, 32'h0000_0000, 5'd0);
    set_prefix(2, 32'hC0A8_0100, 5'd26);
    set_prefix(3, 32'h0000_0000, 5'd30);
    random_leases(250);
    quiet = 1;
    random_leases(150);

    drain_and_settle();
    if (errors == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/plum_pkg.sv
rtl/core/plum_if.sv
rtl/core/plum_ram.sv
rtl/core/plum_front.sv
rtl/core/plum_queue.sv
rtl/core/plum_back.sv
rtl/core/prefix_lease_utilization_monitor.sv
bench/plum_checker.sv
bench/testbench.sv
